// ===== rtl/circumcircle_from_three_points_defines.svh =====
// ----------------------------------------------------------------------------
// circumcircle assertion macros
// shared property wrappers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef CIRCUMCIRCLE_FROM_THREE_POINTS_DEFINES_SVH
`define CIRCUMCIRCLE_FROM_THREE_POINTS_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define CCFP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CCFP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CCFP_ASSERT(lbl, ante, cons, msg)
`define CCFP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/ccfp_pkg.sv =====
// ----------------------------------------------------------------------------
// circumcircle package
// widths, stage indexes and pipeline payload types
// ----------------------------------------------------------------------------
package ccfp_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIF_W  = COORD_BITS + 1;        // point differences
  localparam int PRD_W  = 2 * DIF_W;             // difference products
  localparam int DEN_W  = PRD_W + 2;             // cramer denominator
  localparam int SQS_W  = 2 * COORD_BITS + 1;    // squared lengths
  localparam int NUM_W  = DIF_W + SQS_W + 2;     // cramer numerators
  localparam int QUO_W  = 25;                    // quotient bits kept
  localparam int REM_W  = DEN_W + QUO_W;         // divider remainder
  localparam int CEN_W  = QUO_W + 3;             // unclamped centre
  localparam int OUT_W  = 24;
  localparam int DLT_W  = OUT_W + 1;             // p0 minus centre
  localparam int SQR_W  = 2 * OUT_W + 1;         // squared radius
  localparam int RT_W   = OUT_W + 1;             // raw root
  localparam int TRL_W  = SQR_W + 2;             // root trial value

  localparam int PRE_ST = 7;                     // stages before divider
  localparam int DIV_ST = QUO_W;
  localparam int MID_ST = 4;                     // round, delta, square, sum
  localparam int SQT_ST = RT_W;
  localparam int NST    = PRE_ST + DIV_ST + MID_ST + SQT_ST + 1;
  localparam int ST_DIV_END = PRE_ST + DIV_ST - 1;
  localparam int ST_SQ_BEG  = PRE_ST + DIV_ST + MID_ST - 1;
  localparam int ST_SQ_END  = ST_SQ_BEG + SQT_ST;

  localparam logic signed [CEN_W-1:0] CEN_MAX = CEN_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [CEN_W-1:0] CEN_MIN = -CEN_W'(1 << (OUT_W - 1));

  typedef logic signed [COORD_BITS-1:0] crd_t;

  typedef struct packed {
    crd_t x0;
    crd_t y0;
    crd_t x2;
    crd_t y2;
    crd_t mx;
    crd_t my;
    logic spec;
    logic coll;
  } ctl_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] q;
    logic             neg;
    logic             ovf;
  } lane_t;

  typedef struct packed {
    lane_t            x;
    lane_t            y;
    logic [DEN_W-1:0] dm;
    ctl_t             c;
  } dv_t;

  typedef struct packed {
    logic [SQR_W-1:0]        rem;
    logic [RT_W-1:0]         root;
    logic signed [OUT_W-1:0] cx;
    logic signed [OUT_W-1:0] cy;
    logic                    sat;
    logic                    coll;
  } sq_t;

endpackage

// ===== rtl/circumcircle_from_three_points.sv =====
// ----------------------------------------------------------------------------
// circumcircle from three points
// pipelined circle through three q12.4 points: cramer centre, rounded
// quotients, floor square root radius, saturation and collinear flag
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  in      | in  | in_tvalid / in_tready  | in_tdata: three points
//  out     | out | out_tvalid / out_tready| out_tdata: centre, radius;
//          |     |                        | out_tuser: collinear, saturated
//
// one transaction accepted per cycle while the output is not stalled; the pipe
// holds a 25-stage restoring divider and a 25-stage square root, one bit per stage
// synchronous active-low reset clears only the valid bits
// all stages advance together; when the output register holds an untaken
// result, the whole pipe freezes and in_tready drops, nothing lost or repeated
`include "circumcircle_from_three_points_defines.svh"

module circumcircle_from_three_points
  import ccfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // first_x, first_y, second_x, second_y, third_x, third_y
  input  logic [95:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // center_x, center_y, radius
  output logic [71:0] out_tdata,
  // collinear, saturated
  output logic [1:0]  out_tuser
);

  logic           adv;
  logic [NST-1:0] vld_r;

  // whole pipe moves when the output slot is free or being emptied
  assign adv       = !vld_r[NST-1] || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  // ---- stage 1: capture, differences relative to the third point
  crd_t x0_r, y0_r, x1_r, y1_r, x2_r, y2_r;
  logic signed [DIF_W-1:0] ux_r, uy_r, vx_r, vy_r;
  crd_t x0_nxt, y0_nxt, x1_nxt, y1_nxt, x2_nxt, y2_nxt;

  assign x0_nxt = in_tdata[15:0];
  assign y0_nxt = in_tdata[31:16];
  assign x1_nxt = in_tdata[47:32];
  assign y1_nxt = in_tdata[63:48];
  assign x2_nxt = in_tdata[79:64];
  assign y2_nxt = in_tdata[95:80];

  always_ff @(posedge clk) begin
    if (adv) begin
      x0_r <= x0_nxt; y0_r <= y0_nxt;
      x1_r <= x1_nxt; y1_r <= y1_nxt;
      x2_r <= x2_nxt; y2_r <= y2_nxt;
      ux_r <= DIF_W'(x0_nxt) - DIF_W'(x2_nxt);
      uy_r <= DIF_W'(y0_nxt) - DIF_W'(y2_nxt);
      vx_r <= DIF_W'(x1_nxt) - DIF_W'(x2_nxt);
      vy_r <= DIF_W'(y1_nxt) - DIF_W'(y2_nxt);
    end
  end

  // ---- stage 2: products, coincident-point cases, midpoint
  logic signed [PRD_W-1:0] pa_r, pb_r, puu_r, puy_r, pvx_r, pvy_r;
  logic signed [DIF_W-1:0] ux2_r, uy2_r, vx2_r, vy2_r;
  ctl_t c2_r;
  logic eq01, eq02, eq12;
  logic signed [DIF_W-1:0] smx, smy;
  crd_t mx_nxt, my_nxt;

  assign eq01 = (ux_r == vx_r) && (uy_r == vy_r);
  assign eq02 = (ux_r == '0) && (uy_r == '0);
  assign eq12 = (vx_r == '0) && (vy_r == '0);
  assign smx  = eq01 ? DIF_W'(x0_r) + DIF_W'(x2_r) : DIF_W'(x0_r) + DIF_W'(x1_r);
  assign smy  = eq01 ? DIF_W'(y0_r) + DIF_W'(y2_r) : DIF_W'(y0_r) + DIF_W'(y1_r);

  // halve with ties away from zero
  always_comb begin
    logic signed [DIF_W-1:0] hx, hy;
    hx = smx[DIF_W-1] ? (smx >>> 1) : ((smx + DIF_W'(1)) >>> 1);
    hy = smy[DIF_W-1] ? (smy >>> 1) : ((smy + DIF_W'(1)) >>> 1);
    mx_nxt = hx[COORD_BITS-1:0];
    my_nxt = hy[COORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r  <= PRD_W'(ux_r) * PRD_W'(vy_r);
      pb_r  <= PRD_W'(uy_r) * PRD_W'(vx_r);
      puu_r <= PRD_W'(ux_r) * PRD_W'(ux_r);
      puy_r <= PRD_W'(uy_r) * PRD_W'(uy_r);
      pvx_r <= PRD_W'(vx_r) * PRD_W'(vx_r);
      pvy_r <= PRD_W'(vy_r) * PRD_W'(vy_r);
      ux2_r <= ux_r; uy2_r <= uy_r; vx2_r <= vx_r; vy2_r <= vy_r;
      c2_r  <= '{x0: x0_r, y0: y0_r, x2: x2_r, y2: y2_r, mx: mx_nxt, my: my_nxt,
                 spec: eq01 || eq02 || eq12, coll: 1'b0};
    end
  end

  // ---- stage 3: denominator and squared lengths
  logic signed [DEN_W-1:0] den3_r;
  logic [SQS_W-1:0]        su_r, sv_r;
  logic signed [DIF_W-1:0] ux3_r, uy3_r, vx3_r, vy3_r;
  ctl_t c3_r;
  logic signed [PRD_W:0]   dd;

  assign dd = (PRD_W+1)'(pa_r) - (PRD_W+1)'(pb_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      den3_r <= {dd, 1'b0};
      su_r   <= SQS_W'(puu_r) + SQS_W'(puy_r);
      sv_r   <= SQS_W'(pvx_r) + SQS_W'(pvy_r);
      ux3_r  <= ux2_r; uy3_r <= uy2_r; vx3_r <= vx2_r; vy3_r <= vy2_r;
      c3_r   <= c2_r;
    end
  end

  // ---- stage 4: numerator partial products
  logic signed [NUM_W-1:0] n1a_r, n1b_r, n2a_r, n2b_r;
  logic signed [DEN_W-1:0] den4_r;
  ctl_t c4_r;
  logic signed [SQS_W:0]   sus, svs;

  assign sus = $signed({1'b0, su_r});
  assign svs = $signed({1'b0, sv_r});

  always_ff @(posedge clk) begin
    if (adv) begin
      n1a_r  <= NUM_W'(vy3_r) * NUM_W'(sus);
      n1b_r  <= NUM_W'(uy3_r) * NUM_W'(svs);
      n2a_r  <= NUM_W'(ux3_r) * NUM_W'(svs);
      n2b_r  <= NUM_W'(vx3_r) * NUM_W'(sus);
      den4_r <= den3_r;
      c4_r   <= c3_r;
    end
  end

  // ---- stage 5: numerators, collinear detect
  logic signed [NUM_W-1:0] nx_r, ny_r;
  logic signed [DEN_W-1:0] den5_r;
  ctl_t c5_r;
  ctl_t c5_nxt;

  always_comb begin
    c5_nxt      = c4_r;
    c5_nxt.coll = (den4_r == '0) && !c4_r.spec;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nx_r        <= n1a_r - n1b_r;
      ny_r        <= n2a_r - n2b_r;
      den5_r      <= den4_r;
      c5_r        <= c5_nxt;
    end
  end

  // ---- stage 6: magnitudes and quotient signs
  logic [NUM_W-1:0] nmx_r, nmy_r;
  logic [DEN_W-1:0] dm6_r;
  logic             ngx_r, ngy_r;
  ctl_t c6_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      nmx_r <= nx_r[NUM_W-1] ? NUM_W'(-nx_r) : NUM_W'(nx_r);
      nmy_r <= ny_r[NUM_W-1] ? NUM_W'(-ny_r) : NUM_W'(ny_r);
      dm6_r <= den5_r[DEN_W-1] ? DEN_W'(-den5_r) : DEN_W'(den5_r);
      ngx_r <= nx_r[NUM_W-1] ^ den5_r[DEN_W-1];
      ngy_r <= ny_r[NUM_W-1] ^ den5_r[DEN_W-1];
      c6_r  <= c5_r;
    end
  end

  // ---- stage 7 and divider: quotient overflow check, then one bit a stage
  dv_t dv_r [DIV_ST+1];
  logic [REM_W-1:0] dlim;

  assign dlim = REM_W'(dm6_r) << QUO_W;

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0].x  <= '{rem: REM_W'(nmx_r), q: '0, neg: ngx_r, ovf: REM_W'(nmx_r) >= dlim};
      dv_r[0].y  <= '{rem: REM_W'(nmy_r), q: '0, neg: ngy_r, ovf: REM_W'(nmy_r) >= dlim};
      dv_r[0].dm <= dm6_r;
      dv_r[0].c  <= c6_r;
    end
  end

  for (genvar k = 0; k < DIV_ST; k++) begin : g_div
    logic [REM_W-1:0] trl;
    dv_t              nxt;

    assign trl = REM_W'(dv_r[k].dm) << (QUO_W - 1 - k);

    always_comb begin
      nxt = dv_r[k];
      if (dv_r[k].x.rem >= trl) begin
        nxt.x.rem = dv_r[k].x.rem - trl;
        nxt.x.q[QUO_W-1-k] = 1'b1;
      end
      if (dv_r[k].y.rem >= trl) begin
        nxt.y.rem = dv_r[k].y.rem - trl;
        nxt.y.q[QUO_W-1-k] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[k+1] <= nxt;
      end
    end
  end

  // ---- round, apply sign, add third point (or take the midpoint), clamp
  dv_t dvo;
  logic signed [OUT_W-1:0] cx_nxt, cy_nxt;
  logic                    satc;

  assign dvo = dv_r[DIV_ST];

  always_comb begin
    logic [QUO_W:0]          qmx, qmy;
    logic signed [CEN_W-1:0] cex, cey;
    qmx = dvo.x.ovf ? (QUO_W+1)'(1) << QUO_W
                    : {1'b0, dvo.x.q} + (QUO_W+1)'({dvo.x.rem[DEN_W-1:0], 1'b0}
                                                   >= {1'b0, dvo.dm});
    qmy = dvo.y.ovf ? (QUO_W+1)'(1) << QUO_W
                    : {1'b0, dvo.y.q} + (QUO_W+1)'({dvo.y.rem[DEN_W-1:0], 1'b0}
                                                   >= {1'b0, dvo.dm});
    if (dvo.c.spec) begin
      cex = CEN_W'(dvo.c.mx);
      cey = CEN_W'(dvo.c.my);
    end else begin
      cex = CEN_W'(dvo.c.x2) + (dvo.x.neg ? -CEN_W'(qmx) : CEN_W'(qmx));
      cey = CEN_W'(dvo.c.y2) + (dvo.y.neg ? -CEN_W'(qmy) : CEN_W'(qmy));
    end
    satc = 1'b0;
    if (cex > CEN_MAX) begin
      cx_nxt = OUT_W'(CEN_MAX); satc = 1'b1;
    end else if (cex < CEN_MIN) begin
      cx_nxt = OUT_W'(CEN_MIN); satc = 1'b1;
    end else begin
      cx_nxt = OUT_W'(cex);
    end
    if (cey > CEN_MAX) begin
      cy_nxt = OUT_W'(CEN_MAX); satc = 1'b1;
    end else if (cey < CEN_MIN) begin
      cy_nxt = OUT_W'(CEN_MIN); satc = 1'b1;
    end else begin
      cy_nxt = OUT_W'(cey);
    end
  end

  logic signed [OUT_W-1:0] cxa_r, cya_r, cxb_r, cyb_r, cxc_r, cyc_r;
  logic                    sata_r, satb_r, satc_r, colla_r, collb_r, collc_r;
  crd_t                    x0a_r, y0a_r;
  logic signed [DLT_W-1:0] dx_r, dy_r;
  logic [2*OUT_W-1:0]      sqx_r, sqy_r;
  logic signed [2*DLT_W-1:0] px, py;

  assign px = (2*DLT_W)'(dx_r) * (2*DLT_W)'(dx_r);
  assign py = (2*DLT_W)'(dy_r) * (2*DLT_W)'(dy_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      // centre register
      cxa_r <= cx_nxt; cya_r <= cy_nxt; sata_r <= satc; colla_r <= dvo.c.coll;
      x0a_r <= dvo.c.x0; y0a_r <= dvo.c.y0;
      // offset from p0
      dx_r  <= DLT_W'(x0a_r) - DLT_W'(cxa_r);
      dy_r  <= DLT_W'(y0a_r) - DLT_W'(cya_r);
      cxb_r <= cxa_r; cyb_r <= cya_r; satb_r <= sata_r; collb_r <= colla_r;
      // squares
      sqx_r <= px[2*OUT_W-1:0];
      sqy_r <= py[2*OUT_W-1:0];
      cxc_r <= cxb_r; cyc_r <= cyb_r; satc_r <= satb_r; collc_r <= collb_r;
    end
  end

  // ---- squared radius, then floor square root one bit a stage
  sq_t sq_r [SQT_ST+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r[0] <= '{rem: SQR_W'(sqx_r) + SQR_W'(sqy_r), root: '0, cx: cxc_r,
                   cy: cyc_r, sat: satc_r, coll: collc_r};
    end
  end

  for (genvar k = 0; k < SQT_ST; k++) begin : g_sqrt
    localparam int B = RT_W - 1 - k;
    logic [TRL_W-1:0] trl;
    sq_t              nxt;

    assign trl = (TRL_W'(sq_r[k].root) << (B + 1)) | (TRL_W'(1) << (2 * B));

    always_comb begin
      nxt = sq_r[k];
      if (TRL_W'(sq_r[k].rem) >= trl) begin
        nxt.rem     = sq_r[k].rem - trl[SQR_W-1:0];
        nxt.root[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[k+1] <= nxt;
      end
    end
  end

  // ---- output register: radius clamp, collinear zeroing
  sq_t                     sqo;
  logic [OUT_W-1:0]        rad_r;
  logic signed [OUT_W-1:0] ocx_r, ocy_r;
  logic                    osat_r, ocoll_r;

  assign sqo = sq_r[SQT_ST];

  always_ff @(posedge clk) begin
    if (adv) begin
      ocoll_r <= sqo.coll;
      if (sqo.coll) begin
        ocx_r <= '0; ocy_r <= '0; rad_r <= '0; osat_r <= 1'b0;
      end else begin
        ocx_r  <= sqo.cx;
        ocy_r  <= sqo.cy;
        rad_r  <= sqo.root[RT_W-1] ? '1 : sqo.root[OUT_W-1:0];
        osat_r <= sqo.sat || sqo.root[RT_W-1];
      end
    end
  end

  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = {rad_r, ocy_r, ocx_r};
  assign out_tuser  = {osat_r, ocoll_r};

  // ---- checks
  `CCFP_ASSERT(a_coll_zero, out_tvalid && out_tuser[0], out_tdata == '0 && !out_tuser[1], "collinear result not zeroed")
  `CCFP_ASSERT(a_div_rem, vld_r[ST_DIV_END] && !dvo.c.coll && !dvo.x.ovf && !dvo.y.ovf, dvo.x.rem < REM_W'(dvo.dm) && dvo.y.rem < REM_W'(dvo.dm), "divider remainder not below divisor")
  `CCFP_ASSERT(a_sqrt_rem, vld_r[ST_SQ_END], (SQR_W+1)'(sqo.rem) <= (SQR_W+1)'({sqo.root, 1'b0}), "root remainder too large")
  `CCFP_ASSERT_NXT(a_freeze, !adv, $stable(vld_r), "pipeline moved while stalled")

endmodule
